[rtl/ccpp_pkg.sv]
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types and constants of the cubic curve point projection unit.
// ----------------------------------------------------------------------------
package ccpp_pkg;

    localparam int COORD_W = 24;
    localparam int COEF_W  = 48;
    localparam int SPAN_W  = 32;
    localparam int IDX_W   = 4;

    localparam logic signed [COORD_W-1:0] U_ORIGIN_RST   = 24'sd37143;
    localparam logic        [SPAN_W-1:0]  U_INV_SPAN_RST = 32'd10644986;

    typedef struct packed {
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
    } query_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] u_param;
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] foot_x;
        logic signed [COORD_W-1:0] foot_y;
        logic signed [COORD_W-1:0] echo_x;
        logic signed [COORD_W-1:0] echo_y;
    } result_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  coef_cubic;
        logic signed [COEF_W-1:0]  coef_square;
        logic signed [COEF_W-1:0]  coef_linear;
        logic signed [COEF_W-1:0]  coef_const;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] u_origin;
        logic        [SPAN_W-1:0]  u_inv_span;
    } cfg_t;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_CUBIC  = 4'd0,
        REG_COEF_SQUARE = 4'd1,
        REG_COEF_LINEAR = 4'd2,
        REG_COEF_CONST  = 4'd3,
        REG_LEFT_X      = 4'd4,
        REG_RIGHT_X     = 4'd5,
        REG_U_ORIGIN    = 4'd6,
        REG_U_INV_SPAN  = 4'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_AX  = 3'd0,
        OP_YC  = 3'd1,
        OP_SC  = 3'd2,
        OP_YD  = 3'd3,
        OP_DOT = 3'd4,
        OP_U   = 3'd5
    } op_t;

    typedef struct packed {
        logic load_query;
        logic calc_mid;
        logic mul_lo;
        logic mul_hi;
        logic post;
        logic load_out;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic more;
    } sts_t;

endpackage

[rtl/ccpp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ccpp_cfg_regs
// Configuration register file: curve coefficients, interval and u mapping.
// ----------------------------------------------------------------------------
module ccpp_cfg_regs
    import ccpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_index,
    input  logic [COEF_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_COEF_CUBIC:  cfg_next.coef_cubic  = wr_data;
                REG_COEF_SQUARE: cfg_next.coef_square = wr_data;
                REG_COEF_LINEAR: cfg_next.coef_linear = wr_data;
                REG_COEF_CONST:  cfg_next.coef_const  = wr_data;
                REG_LEFT_X:      cfg_next.left_x      = wr_data[COORD_W-1:0];
                REG_RIGHT_X:     cfg_next.right_x     = wr_data[COORD_W-1:0];
                REG_U_ORIGIN:    cfg_next.u_origin    = wr_data[COORD_W-1:0];
                REG_U_INV_SPAN:  cfg_next.u_inv_span  = wr_data[SPAN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_cubic  <= '0;
            cfg_reg.coef_square <= '0;
            cfg_reg.coef_linear <= '0;
            cfg_reg.coef_const  <= '0;
            cfg_reg.left_x      <= '0;
            cfg_reg.right_x     <= '0;
            cfg_reg.u_origin    <= U_ORIGIN_RST;
            cfg_reg.u_inv_span  <= U_INV_SPAN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/ccpp_ctrl.sv]
// ----------------------------------------------------------------------------
// ccpp_ctrl
// Sequencer: steps the datapath through midpoint, products, sign test and
// the final parameter product, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ccpp_ctrl
    import ccpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MID    = 7'b0000010,
        S_MUL_LO = 7'b0000100,
        S_MUL_HI = 7'b0001000,
        S_POST   = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_query = 1'b1;
                    op_next        = OP_AX;
                    state_next     = S_MID;
                end
            end
            S_MID:
            begin
                cmd.calc_mid = 1'b1;
                state_next   = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                cmd.post = 1'b1;
                unique case (op_reg)
                    OP_AX:
                    begin
                        op_next    = OP_YC;
                        state_next = S_MUL_LO;
                    end
                    OP_YC:
                    begin
                        op_next    = OP_SC;
                        state_next = S_MUL_LO;
                    end
                    OP_SC:
                    begin
                        op_next    = OP_YD;
                        state_next = S_MUL_LO;
                    end
                    OP_YD:
                    begin
                        op_next    = OP_DOT;
                        state_next = S_MUL_LO;
                    end
                    OP_DOT:  state_next = S_CHECK;
                    OP_U:    state_next = S_OUT;
                    default: state_next = S_IDLE;
                endcase
            end
            S_CHECK:
            begin
                if (sts.more)
                begin
                    op_next    = OP_AX;
                    state_next = S_MID;
                end
                else
                begin
                    op_next    = OP_U;
                    state_next = S_MUL_LO;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_AX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/ccpp_dpath.sv]
// ----------------------------------------------------------------------------
// ccpp_dpath
// Bisection datapath: interval registers, one shared 24x25 multiplier used
// in two halves per product, saturating post-processing and result register.
// ----------------------------------------------------------------------------
module ccpp_dpath
    import ccpp_pkg::*;
#(
    parameter int MAX_ITERATIONS = 32,
    parameter int FRAC_BITS      = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output sts_t    sts,
    input  cfg_t    cfg,
    input  query_t  query,
    output result_t result
);

    localparam int IW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [72:0] LIM47_W = 73'h7FFF_FFFF_FFFF;
    localparam logic [72:0] LIM23_W = 73'h7F_FFFF;

    logic signed [23:0] qx_reg, qy_reg, xl_reg, xr_reg, xm_reg, ym_reg, u_reg;
    logic signed [47:0] y_reg, s_reg;
    logic [IW-1:0]      iter_reg;
    logic [72:0]        prod_reg;
    logic               neg_reg;
    result_t            res_reg;

    logic signed [48:0] a_sel;
    logic [47:0]        a_mag;
    logic signed [24:0] b_sel;
    logic [24:0]        b_mag;
    logic [48:0]        part;
    logic signed [24:0] mid_sum;
    logic [72:0]        mag_sh;
    logic [46:0]        mag47;
    logic signed [51:0] p52;
    logic signed [51:0] add52;
    logic signed [47:0] sum_sat;
    logic signed [47:0] slope_sat;
    logic signed [47:0] y_shift;
    logic signed [74:0] dot_sum;
    logic signed [24:0] dx;
    logic [72:0]        mag_u;
    logic [22:0]        u_mag;
    logic signed [24:0] width;
    logic signed [30:0] width20;

    function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
        if (v > 52'sh7FFF_FFFF_FFFF)
            sat48 = 48'sh7FFF_FFFF_FFFF;
        else if (v < -52'sh8000_0000_0000)
            sat48 = 48'sh8000_0000_0000;
        else
            sat48 = v[47:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sh7F_FFFF)
            sat24 = 24'sh7F_FFFF;
        else if (v < -48'sh80_0000)
            sat24 = 24'sh80_0000;
        else
            sat24 = v[23:0];
    endfunction

    always_comb
    begin
        unique case (cmd.op)
            OP_AX:   a_sel = 49'(cfg.coef_cubic);
            OP_YC:   a_sel = 49'(y_reg);
            OP_YD:   a_sel = 49'(y_reg);
            OP_SC:   a_sel = 49'(s_reg);
            OP_DOT:  a_sel = 49'(s_reg);
            OP_U:    a_sel = $signed({17'b0, cfg.u_inv_span});
            default: a_sel = '0;
        endcase
        unique case (cmd.op)
            OP_DOT:  b_sel = 25'(ym_reg) - 25'(qy_reg);
            OP_U:    b_sel = 25'(xm_reg) - 25'(cfg.u_origin);
            default: b_sel = 25'(xm_reg);
        endcase
    end

    assign a_mag = a_sel[48] ? 48'(-a_sel) : a_sel[47:0];
    assign b_mag = b_sel[24] ? 25'(-b_sel) : 25'(b_sel);
    assign part  = (cmd.mul_hi ? a_mag[47:24] : a_mag[23:0]) * b_mag;

    assign mid_sum = 25'(xl_reg) + 25'(xr_reg);

    // saturating product rescaled to Q15.32
    assign mag_sh = prod_reg >> FRAC_BITS;
    assign mag47  = (mag_sh > LIM47_W) ? 47'h7FFF_FFFF_FFFF : mag_sh[46:0];
    assign p52    = neg_reg ? -$signed({5'b0, mag47}) : $signed({5'b0, mag47});

    always_comb
    begin
        unique case (cmd.op)
            OP_AX:   add52 = 52'(cfg.coef_square);
            OP_YD:   add52 = 52'(cfg.coef_const);
            default: add52 = 52'(cfg.coef_linear);
        endcase
    end

    assign sum_sat   = sat48(p52 + add52);
    assign slope_sat = sat48(3 * p52 + 2 * 52'(cfg.coef_square));
    assign y_shift   = sum_sat >>> (32 - FRAC_BITS);

    assign dx      = 25'(xm_reg) - 25'(qx_reg);
    assign dot_sum = (neg_reg ? -$signed({2'b0, prod_reg}) : $signed({2'b0, prod_reg}))
                     + (75'(dx) <<< 32);

    assign mag_u = prod_reg >> (FRAC_BITS + 16);
    assign u_mag = (mag_u > LIM23_W) ? 23'h7F_FFFF : mag_u[22:0];

    assign width    = 25'(xr_reg) - 25'(xl_reg);
    assign width20  = 31'(width) * 31'sd20;
    assign sts.more = (width20 > (31'sd1 <<< FRAC_BITS))
                      && (iter_reg < IW'(MAX_ITERATIONS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.load_query)
        begin
            iter_reg <= '0;
        end
        else if (cmd.post && cmd.op == OP_DOT)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            qx_reg <= query.query_x;
            qy_reg <= query.query_y;
            xl_reg <= cfg.left_x;
            xr_reg <= cfg.right_x;
        end
        if (cmd.calc_mid)
        begin
            xm_reg <= 24'(mid_sum >>> 1);
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= 73'(part);
            neg_reg  <= a_sel[48] ^ b_sel[24];
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + (73'(part) << 24);
        end
        if (cmd.post)
        begin
            case (cmd.op)
                OP_AX:
                begin
                    y_reg <= sum_sat;
                    s_reg <= slope_sat;
                end
                OP_YC: y_reg <= sum_sat;
                OP_SC: s_reg <= sum_sat;
                OP_YD:
                begin
                    y_reg  <= sum_sat;
                    ym_reg <= sat24(y_shift);
                end
                OP_DOT:
                begin
                    if (dot_sum > 75'sd0)
                        xr_reg <= xm_reg;
                    else
                        xl_reg <= xm_reg;
                end
                OP_U: u_reg <= neg_reg ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            res_reg.u_param <= u_reg;
            res_reg.vec_x   <= sat24(48'(25'(qx_reg) - 25'(xm_reg)));
            res_reg.vec_y   <= sat24(48'(25'(qy_reg) - 25'(ym_reg)));
            res_reg.foot_x  <= xm_reg;
            res_reg.foot_y  <= ym_reg;
            res_reg.echo_x  <= qx_reg;
            res_reg.echo_y  <= qy_reg;
        end
    end

    assign result = res_reg;

endmodule

[rtl/cubic_curve_point_projection_unit.sv]
// ----------------------------------------------------------------------------
// cubic_curve_point_projection_unit
// Projects a query point onto a configured cubic by bisection of x.
//
//   channel | signals                               | word
//   in      | in_valid, in_ready, in_data           | query_t
//   out     | out_valid, out_ready, out_data        | result_t
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | register write
//
// Each word takes N midpoints (1..MAX_ITERATIONS) from accept to result:
// each midpoint step computes the midpoint, runs five products through the
// single shared multiplier, each as a low half, a high half and a post step,
// and then tests the interval; the u product and the output load follow.
// The next word can be accepted in the cycle after the result is loaded.
// Reset: asynchronous, active low; the datapath data registers have no reset.
// A waiting result holds in the output register while the next word is
// accepted; the finish step waits only if that register is still full.
// ----------------------------------------------------------------------------
module cubic_curve_point_projection_unit
    import ccpp_pkg::*;
#(
    parameter int MAX_ITERATIONS = 32,
    parameter int FRAC_BITS      = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  query_t             in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]  cfg_data
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ccpp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ccpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ccpp_dpath #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .cfg    (cfg),
        .query  (in_data),
        .result (out_data)
    );

endmodule

[rtl/ccpp_checker.sv]
// ----------------------------------------------------------------------------
// ccpp_checker
// Port-level checks of the projection unit, bound to the top level.
// ----------------------------------------------------------------------------
module ccpp_checker
    import ccpp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input query_t             in_data,
    input logic               out_valid,
    input logic               out_ready,
    input result_t            out_data,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [IDX_W-1:0]   cfg_index,
    input logic [COEF_W-1:0]  cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken during a search");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted without returning to idle");

    a_no_result_when_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !out_valid |=> !out_valid)
        else $error("result appeared without a search");

endmodule

bind cubic_curve_point_projection_unit ccpp_checker u_ccpp_checker (.*);

[tb/sv/cubic_curve_point_projection_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_curve_point_projection_unit_checker
// Watches the query, result and register channels of the projection unit,
// computes each expected foot point by bisection in 128-bit arithmetic, and
// compares every result word as a whole, in arrival order.
// ----------------------------------------------------------------------------
module cubic_curve_point_projection_unit_checker
    import ccpp_pkg::*;
#(
    parameter int MAX_ITERATIONS = 32,
    parameter int FRAC_BITS      = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  query_t            in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  result_t           out_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending
);

    typedef logic signed [127:0] wide_t;

    localparam wide_t LIM47 = (wide_t'(1) <<< 47) - 1;
    localparam wide_t LIM23 = (wide_t'(1) <<< 23) - 1;

    cfg_t    curve;
    result_t foot_queue[$];

    function automatic wide_t clamp(wide_t v, wide_t lim);
        if (v > lim)
            return lim;
        if (v < -lim - 1)
            return -lim - 1;
        return v;
    endfunction

    // product shifted down toward zero, magnitude saturated
    function automatic wide_t scaled_product(wide_t a, wide_t b, int s, wide_t lim);
        wide_t p;
        wide_t m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> s;
        if (m > lim)
            m = lim;
        return (p < 0) ? -m : m;
    endfunction

    function automatic wide_t curve_at(wide_t x);
        wide_t acc;
        acc = clamp(scaled_product(curve.coef_cubic, x, FRAC_BITS, LIM47)
                    + curve.coef_square, LIM47);
        acc = clamp(scaled_product(acc, x, FRAC_BITS, LIM47) + curve.coef_linear, LIM47);
        acc = clamp(scaled_product(acc, x, FRAC_BITS, LIM47) + curve.coef_const, LIM47);
        return acc;
    endfunction

    function automatic wide_t slope_at(wide_t x);
        wide_t acc;
        acc = clamp(3 * scaled_product(curve.coef_cubic, x, FRAC_BITS, LIM47)
                    + 2 * wide_t'(curve.coef_square), LIM47);
        acc = clamp(scaled_product(acc, x, FRAC_BITS, LIM47) + curve.coef_linear, LIM47);
        return acc;
    endfunction

    function automatic result_t project_point(query_t q);
        result_t r;
        wide_t   qx, qy, xl, xr, xm, ym, sl, u;
        int      n;
        qx = q.query_x;
        qy = q.query_y;
        xl = curve.left_x;
        xr = curve.right_x;
        n  = 0;
        do
        begin
            xm = (xl + xr) >>> 1;
            ym = clamp(curve_at(xm) >>> (32 - FRAC_BITS), LIM23);
            sl = slope_at(xm);
            if (((xm - qx) <<< 32) + (ym - qy) * sl > 0)
                xr = xm;
            else
                xl = xm;
            n++;
        end
        while ((xr - xl) * 20 > (wide_t'(1) <<< FRAC_BITS) && n < MAX_ITERATIONS);
        u = scaled_product(xm - wide_t'(curve.u_origin), wide_t'({1'b0, curve.u_inv_span}),
                           FRAC_BITS + 16, LIM23);
        r.u_param = u[23:0];
        r.vec_x   = 24'(clamp(qx - xm, LIM23));
        r.vec_y   = 24'(clamp(qy - ym, LIM23));
        r.foot_x  = xm[23:0];
        r.foot_y  = ym[23:0];
        r.echo_x  = q.query_x;
        r.echo_y  = q.query_y;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve <= '{coef_cubic:  '0,
                       coef_square: '0,
                       coef_linear: '0,
                       coef_const:  '0,
                       left_x:      '0,
                       right_x:     '0,
                       u_origin:    U_ORIGIN_RST,
                       u_inv_span:  U_INV_SPAN_RST};
            fail_count <= 0;
            pending    <= 0;
            foot_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_COEF_CUBIC:  curve.coef_cubic  <= cfg_data;
                    REG_COEF_SQUARE: curve.coef_square <= cfg_data;
                    REG_COEF_LINEAR: curve.coef_linear <= cfg_data;
                    REG_COEF_CONST:  curve.coef_const  <= cfg_data;
                    REG_LEFT_X:      curve.left_x      <= cfg_data[23:0];
                    REG_RIGHT_X:     curve.right_x     <= cfg_data[23:0];
                    REG_U_ORIGIN:    curve.u_origin    <= cfg_data[23:0];
                    REG_U_INV_SPAN:  curve.u_inv_span  <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                foot_queue.insert(foot_queue.size(), project_point(in_data));
            if (out_valid && out_ready)
            begin
                if (foot_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else if (out_data !== foot_queue[0])
                begin
                    if (fail_count < 10)
                    begin
                        $display("mismatch: expected u=%h vx=%h vy=%h fx=%h fy=%h ex=%h ey=%h",
                                 foot_queue[0].u_param, foot_queue[0].vec_x,
                                 foot_queue[0].vec_y, foot_queue[0].foot_x,
                                 foot_queue[0].foot_y, foot_queue[0].echo_x,
                                 foot_queue[0].echo_y);
                        $display("          got      u=%h vx=%h vy=%h fx=%h fy=%h ex=%h ey=%h",
                                 out_data.u_param, out_data.vec_x, out_data.vec_y,
                                 out_data.foot_x, out_data.foot_y,
                                 out_data.echo_x, out_data.echo_y);
                    end
                    fail_count <= fail_count + 1;
                    void'(foot_queue.pop_front());
                end
                else
                    void'(foot_queue.pop_front());
            end
            pending <= foot_queue.size();
        end
    end

endmodule

[tb/sv/cubic_curve_point_projection_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_curve_point_projection_unit_test
// Drives query words and register writes into the projection unit under
// bursty input and stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module cubic_curve_point_projection_unit_test;
    import ccpp_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    query_t            in_data;
    logic              out_valid;
    logic              out_ready;
    result_t           out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    int                stall_mode;

    cubic_curve_point_projection_unit DUT (.*);

    cubic_curve_point_projection_unit_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall pattern: phases of free flow, random and heavy stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("cubic_curve_point_projection_unit_test NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (600)
            @(posedge clk);
    endtask

    task automatic send_query(logic [23:0] qx, logic [23:0] qy);
        in_valid <= 1'b1;
        in_data  <= '{query_x: qx, query_y: qy};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic logic [47:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'({$urandom, $urandom});
            default: return 48'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    task automatic load_curve(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                              logic [47:0] d, logic [23:0] lx, logic [23:0] rx,
                              logic [23:0] uo, logic [31:0] us);
        drain();
        write_reg(REG_COEF_CUBIC, a);
        write_reg(REG_COEF_SQUARE, b);
        write_reg(REG_COEF_LINEAR, c);
        write_reg(REG_COEF_CONST, d);
        write_reg(REG_LEFT_X, {{24{lx[23]}}, lx});
        write_reg(REG_RIGHT_X, {{24{rx[23]}}, rx});
        write_reg(REG_U_ORIGIN, {{24{uo[23]}}, uo});
        write_reg(REG_U_INV_SPAN, {16'd0, us});
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        stall_mode = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty interval, one midpoint
        send_query(24'h7FFFFF, 24'h800000);
        send_query(24'h000000, 24'h000000);

        // parabola over a wide interval
        load_curve(48'sd0, 48'sd4294967296, 48'sd0, 48'sd0, -24'sd2560, 24'sd2560,
                   24'sd0, 32'hFFFFFFFF);
        send_query(24'h7FFFFF, 24'h7FFFFF);
        send_query(24'h800000, 24'h800000);
        send_query(24'sd256, 24'sd512);
        send_query(24'sd0, 24'sd0);
        send_query(24'h555555, 24'hAAAAAA);

        // reversed interval and extreme coefficients
        load_curve(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                   48'h8000_0000_0000, 24'h7FFFFF, 24'h800000, 24'h800000, 32'd0);
        send_query(24'sd100, 24'sd100);
        send_query(24'h7FFFFF, 24'h000000);

        // full range interval, ends on the width test before the iteration cap
        load_curve(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                   48'h7FFF_FFFF_FFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFFFFFF);
        send_query(24'h800000, 24'h7FFFFF);
        send_query(24'sd1, 24'sd1);

        // narrow interval at the width threshold
        load_curve(48'sd4294967, 48'sd0, 48'sd4294967296, 48'sd0, 24'sd0, 24'sd13,
                   U_ORIGIN_RST, U_INV_SPAN_RST);
        send_query(24'sd5, 24'sd7);
        send_query(24'h7FFFFF, 24'h800000);

        for (int phase = 0; phase < 10; phase++)
        begin
            load_curve(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coord(), rand_coord(), rand_coord(), $urandom);
            for (int k = 0; k < 70; )
            begin
                int burst;
                stall_mode = $urandom_range(0, 2);
                burst = $urandom_range(1, 12);
                for (int j = 0; j < burst && k < 70; j++, k++)
                    send_query(rand_coord(), rand_coord());
                if ($urandom_range(0, 5) == 0)
                begin
                    while (pending != 0)
                        @(posedge clk);
                end
                else
                    repeat ($urandom_range(0, 200))
                        @(posedge clk);
            end
        end

        stall_mode = 0;
        drain();
        if (fail_count == 0)
            $display("cubic_curve_point_projection_unit_test OK");
        else
            $display("cubic_curve_point_projection_unit_test NOT OK");
        $finish;
    end

endmodule
